// ===== hdl/hds_pkg.sv =====
package hds_pkg;

	localparam int MAX_WIDTH_DEFAULT = 1024;
	localparam int MIN_SIZE          = 3;

	localparam int TEMP_W      = 32;
	localparam int COND_W      = 16;
	localparam int GRID_WIDTH_W  = 11;
	localparam int GRID_HEIGHT_W = 16;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 4'd1;

	localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RESET  = 11'd64;
	localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RESET = 16'd64;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic        [COND_W-1:0] conductivity;
		logic signed [TEMP_W-1:0] heating;
		logic                     pad;
	} point_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] new_temperature;
		logic                     frame_end;
	} update_t;

endpackage

// ===== hdl/heat_diffusion_stencil_step_core.sv =====
// Streaming five-point heat diffusion step. Grid points enter in raster order, one
// word per point, each carrying its old temperature (Q16.16), conductivity (Q0.16)
// and heating (Q16.16); the updated grid leaves one row late, also in raster order,
// and the word for the last point of a frame is flagged with frame_end. Interior
// points become old + floor(k * (left + right + up + down - 4*centre)) + heat,
// saturated to 32 bits, with left and up taken from already updated values; border
// points pass through. After each frame, send one row of pad words to drain the last
// row; pad words at any other time are dropped. The block takes one point per clock
// cycle while update_ready is held high: the line stores are read as a point enters,
// the stencil arithmetic runs in the single stage after that, and the left-neighbour
// feedback closes within that one stage. The result a word causes is computed from
// stage 1 and registered in the output register, where it waits until it is taken.
// The line stores need no clearing pass after reset. Write grid_width and
// grid_height only between frames while the block is idle.
module heat_diffusion_stencil_step_core #(
	parameter int MAX_WIDTH = hds_pkg::MAX_WIDTH_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  point_valid,
	output logic                                  point_ready,
	input  hds_pkg::point_t                       point,

	output logic                                  update_valid,
	input  logic                                  update_ready,
	output hds_pkg::update_t                      update,

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [hds_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [hds_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	// configuration
	logic [hds_pkg::GRID_WIDTH_W-1:0]  grid_width_q;
	logic [hds_pkg::GRID_HEIGHT_W-1:0] grid_height_q;

	// raster position of the next word
	logic [CW-1:0]                     col_q;
	logic [hds_pkg::GRID_HEIGHT_W-1:0] row_q;

	// input decode
	logic [31:0]   width_raw;
	logic [31:0]   width_eff;
	logic [31:0]   col_raw;
	logic [31:0]   col_eff;
	logic [CW-1:0] col_idx;
	logic [CW-1:0] right_idx;
	logic [hds_pkg::GRID_HEIGHT_W-1:0] height_eff;
	logic          last_col;
	logic          drain;
	logic          take;
	logic          process;
	logic          load_s1;
	logic          line_wr;
	logic          border;

	// stage 1
	logic                             valid_s1;
	logic signed [hds_pkg::TEMP_W-1:0] temp_s1;
	logic [CW-1:0]                    col_s1;
	logic                             border_s1;
	logic                             frame_end_s1;
	logic                             s1_go;

	// line store read data, aligned with stage 1
	logic [hds_pkg::TEMP_W-1:0] centre_rd;
	logic [hds_pkg::TEMP_W-1:0] right_rd;
	logic [hds_pkg::TEMP_W-1:0] up_rd;
	logic [hds_pkg::COND_W-1:0] cond_rd;
	logic [hds_pkg::TEMP_W-1:0] heat_rd;

	// stencil arithmetic
	logic signed [35:0]                 lap;
	logic signed [hds_pkg::COND_W:0]    cond_ext;
	logic signed [52:0]                 prod;
	logic signed [36:0]                 term;
	logic signed [38:0]                 total;
	logic signed [hds_pkg::TEMP_W-1:0]  sat;
	logic signed [hds_pkg::TEMP_W-1:0]  result;

	logic signed [hds_pkg::TEMP_W-1:0] left_q;
	logic                              update_valid_q;
	hds_pkg::update_t                  update_q;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= hds_pkg::GRID_WIDTH_RESET;
			grid_height_q <= hds_pkg::GRID_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hds_pkg::CFG_GRID_WIDTH: begin
					grid_width_q <= cfg_data[hds_pkg::GRID_WIDTH_W-1:0];
				end
				hds_pkg::CFG_GRID_HEIGHT: begin
					grid_height_q <= cfg_data[hds_pkg::GRID_HEIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp the sizes and the column, then classify the incoming word.
	always_comb begin
		width_raw = 32'(grid_width_q);
		if (width_raw < 32'(hds_pkg::MIN_SIZE)) begin
			width_eff = 32'(hds_pkg::MIN_SIZE);
		end else if (width_raw > 32'(MAX_WIDTH)) begin
			width_eff = 32'(MAX_WIDTH);
		end else begin
			width_eff = width_raw;
		end

		if (grid_height_q < hds_pkg::GRID_HEIGHT_W'(hds_pkg::MIN_SIZE)) begin
			height_eff = hds_pkg::GRID_HEIGHT_W'(hds_pkg::MIN_SIZE);
		end else begin
			height_eff = grid_height_q;
		end

		// a column at or beyond the width counts as the last one
		col_raw   = 32'(col_q);
		col_eff   = (col_raw >= width_eff) ? width_eff - 32'd1 : col_raw;
		col_idx   = CW'(col_eff);
		last_col  = (col_eff == width_eff - 32'd1);
		// the right neighbour of the last column is never used
		right_idx = last_col ? '0 : CW'(col_eff + 32'd1);

		drain   = (row_q >= height_eff);
		take    = point_valid && point_ready;
		// drop pad words outside the drain row
		process = take && !(point.pad && !drain);
		// the first row only fills the line stores
		load_s1 = process && (row_q != '0);
		line_wr = process && !drain;
		border  = drain || (row_q == hds_pkg::GRID_HEIGHT_W'(1)) ||
		          (col_eff == 32'd0) || last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (process) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= drain ? '0 : row_q + hds_pkg::GRID_HEIGHT_W'(1);
			end else begin
				col_q <= CW'(col_eff + 32'd1);
			end
		end
	end

	// Old temperature is kept twice so centre and right neighbour are read in the same cycle.
	hds_ram #(.WIDTH(hds_pkg::TEMP_W), .DEPTH(MAX_WIDTH)) u_centre_line (
		.clk     (clk),
		.wr_en   (line_wr),
		.wr_addr (col_idx),
		.wr_data (point.temperature),
		.rd_en   (load_s1),
		.rd_addr (col_idx),
		.rd_data (centre_rd)
	);

	hds_ram #(.WIDTH(hds_pkg::TEMP_W), .DEPTH(MAX_WIDTH)) u_right_line (
		.clk     (clk),
		.wr_en   (line_wr),
		.wr_addr (col_idx),
		.wr_data (point.temperature),
		.rd_en   (load_s1),
		.rd_addr (right_idx),
		.rd_data (right_rd)
	);

	hds_ram #(.WIDTH(hds_pkg::COND_W), .DEPTH(MAX_WIDTH)) u_cond_line (
		.clk     (clk),
		.wr_en   (line_wr),
		.wr_addr (col_idx),
		.wr_data (point.conductivity),
		.rd_en   (load_s1),
		.rd_addr (col_idx),
		.rd_data (cond_rd)
	);

	hds_ram #(.WIDTH(hds_pkg::TEMP_W), .DEPTH(MAX_WIDTH)) u_heat_line (
		.clk     (clk),
		.wr_en   (line_wr),
		.wr_addr (col_idx),
		.wr_data (point.heating),
		.rd_en   (load_s1),
		.rd_addr (col_idx),
		.rd_data (heat_rd)
	);

	// updated values of the row above the one being emitted
	hds_ram #(.WIDTH(hds_pkg::TEMP_W), .DEPTH(MAX_WIDTH)) u_up_line (
		.clk     (clk),
		.wr_en   (s1_go),
		.wr_addr (col_s1),
		.wr_data (result),
		.rd_en   (load_s1),
		.rd_addr (col_idx),
		.rd_data (up_rd)
	);

	// Stage 1 advances whenever the output register is free or being emptied;
	// an empty stage 1 takes a word even while a result waits.
	assign s1_go       = valid_s1 && (!update_valid_q || update_ready);
	assign point_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (point_ready) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			temp_s1      <= point.temperature;
			col_s1       <= col_idx;
			border_s1    <= border;
			frame_end_s1 <= drain && last_col;
		end
	end

	// Laplacian, scale by conductivity with floor, add heating, saturate.
	always_comb begin
		lap = 36'(left_q) + 36'($signed(right_rd)) + 36'($signed(up_rd)) + 36'(temp_s1)
		    - (36'($signed(centre_rd)) <<< 2);
		cond_ext = {1'b0, cond_rd};
		prod     = 53'(cond_ext) * 53'(lap);
		// dropping the low bits of a two's complement value floors it
		term     = prod[52:16];
		total    = 39'($signed(centre_rd)) + 39'(term) + 39'($signed(heat_rd));
		if (total[38:31] != {8{total[38]}}) begin
			sat = total[38] ? {1'b1, {(hds_pkg::TEMP_W-1){1'b0}}}
			                : {1'b0, {(hds_pkg::TEMP_W-1){1'b1}}};
		end else begin
			sat = total[hds_pkg::TEMP_W-1:0];
		end
		result = border_s1 ? $signed(centre_rd) : sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_valid_q <= 1'b0;
			left_q         <= '0;
		end else if (s1_go) begin
			update_valid_q <= 1'b1;
			left_q         <= result;
		end else if (update_ready) begin
			update_valid_q <= 1'b0;
		end
	end

	// hold the word until it is taken
	always_ff @(posedge clk) begin
		if (s1_go) begin
			update_q.new_temperature <= result;
			update_q.frame_end       <= frame_end_s1;
		end
	end

	assign update_valid = update_valid_q;
	assign update       = update_q;

endmodule

// ===== hdl/hds_ram.sv =====
module hds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// read-first: a read and a write at the same address return the old word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== verif/tb_heat_diffusion_stencil_step_core.sv =====
`timescale 1ns / 100ps

module tb_heat_diffusion_stencil_step_core;

	typedef hds_pkg::point_t  point_t;
	typedef hds_pkg::update_t update_t;

	localparam int TEMP_W        = hds_pkg::TEMP_W;
	localparam int COND_W        = hds_pkg::COND_W;
	localparam int GRID_WIDTH_W  = hds_pkg::GRID_WIDTH_W;
	localparam int GRID_HEIGHT_W = hds_pkg::GRID_HEIGHT_W;
	localparam int CFG_INDEX_W   = hds_pkg::CFG_INDEX_W;
	localparam int CFG_DATA_W    = hds_pkg::CFG_DATA_W;

	localparam int GRID_MAX       = hds_pkg::MAX_WIDTH_DEFAULT;
	localparam int RANDOM_POINTS  = 400;
	localparam int MAX_GAP        = 8;
	// idle time after the last expected update; give dropped pads time to clear too
	localparam int SETTLE_CYCLES  = 6;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int STALL_PCT      = 38;

	localparam logic [TEMP_W-1:0] TEMP_TOP    = 32'h7FFF_FFFF;
	localparam logic [TEMP_W-1:0] TEMP_BOTTOM = 32'h8000_0000;
	localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

	// no register sits at this index: the write must leave both sizes alone
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 4'd15;

	// Expected-update store plus a bit-accurate copy of the stencil: line stores,
	// left feedback, raster position and the two size registers.
	class stencil_scoreboard;
		logic [TEMP_W-1:0] up_line   [GRID_MAX];
		logic [TEMP_W-1:0] prev_line [GRID_MAX];
		logic [COND_W-1:0] k_line    [GRID_MAX];
		logic [TEMP_W-1:0] q_line    [GRID_MAX];
		logic [TEMP_W-1:0] left_new;
		int unsigned row_pos;
		int unsigned col_pos;
		logic [GRID_WIDTH_W-1:0]  width_reg;
		logic [GRID_HEIGHT_W-1:0] height_reg;
		update_t expected_q[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned clipped;
		int unsigned frames;

		function new();
			for (int i = 0; i < GRID_MAX; i++) begin
				up_line[i]   = '0;
				prev_line[i] = '0;
				k_line[i]    = '0;
				q_line[i]    = '0;
			end
			left_new   = '0;
			row_pos    = 0;
			col_pos    = 0;
			width_reg  = hds_pkg::GRID_WIDTH_RESET;
			height_reg = hds_pkg::GRID_HEIGHT_RESET;
			errors     = 0;
			checked    = 0;
			clipped    = 0;
			frames     = 0;
		endfunction

		function int unsigned cols();
			int unsigned w;
			w = 32'(width_reg);
			if (w < hds_pkg::MIN_SIZE) w = hds_pkg::MIN_SIZE;
			if (w > GRID_MAX) w = GRID_MAX;
			return w;
		endfunction

		function int unsigned rows();
			int unsigned h;
			h = 32'(height_reg);
			if (h < hds_pkg::MIN_SIZE) h = hds_pkg::MIN_SIZE;
			return h;
		endfunction

		function int unsigned waiting();
			return expected_q.size();
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			hds_pkg::CFG_GRID_WIDTH:  width_reg  = data[GRID_WIDTH_W-1:0];
			hds_pkg::CFG_GRID_HEIGHT: height_reg = data[GRID_HEIGHT_W-1:0];
			default: ;
			endcase
		endfunction

		// Returns 0 for a stray pad, which the block drops without a trace.
		function bit note_point(point_t p);
			int unsigned w;
			int unsigned h;
			int unsigned r;
			int unsigned c;
			int unsigned er;
			bit drain;
			longint centre;
			longint lap;
			longint term;
			longint sum;
			logic [TEMP_W-1:0] res;
			update_t u;
			w = cols();
			h = rows();
			r = row_pos;
			c = col_pos;
			if (c >= w) c = w - 1;
			drain = (r >= h);
			if (p.pad && !drain) return 1'b0;

			if (r >= 1) begin
				er = drain ? h - 1 : r - 1;
				if (er == 0 || er == h - 1 || c == 0 || c == w - 1) begin
					res = prev_line[c];
				end else begin
					centre = longint'($signed(prev_line[c]));
					lap = longint'($signed(left_new)) + longint'($signed(prev_line[c + 1]))
					    + longint'($signed(up_line[c])) + longint'(p.temperature) - 4 * centre;
					term = (longint'(k_line[c]) * lap) >>> 16;
					sum = centre + term + longint'($signed(q_line[c]));
					if (sum > SAT_HI || sum < SAT_LO) clipped++;
					if (sum > SAT_HI) sum = SAT_HI;
					if (sum < SAT_LO) sum = SAT_LO;
					res = sum[TEMP_W-1:0];
				end
				up_line[c] = res;
				left_new = res;
				u.new_temperature = res;
				u.frame_end = drain && (c == w - 1);
				if (u.frame_end) frames++;
				expected_q.push_back(u);
			end

			if (!drain) begin
				prev_line[c] = p.temperature;
				k_line[c]    = p.conductivity;
				q_line[c]    = p.heating;
			end

			if (c + 1 >= w) begin
				col_pos = 0;
				row_pos = drain ? 0 : (r + 1) & 16'hFFFF;
			end else begin
				col_pos = c + 1;
			end
			return 1'b1;
		endfunction

		function void check_update(update_t got);
			update_t want;
			checked++;
			if (expected_q.size() == 0) begin
				$error("unexpected update: new_temperature %0d frame_end %0b",
				       got.new_temperature, got.frame_end);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.new_temperature !== want.new_temperature) begin
				$error("new_temperature: expected %0d, got %0d",
				       want.new_temperature, got.new_temperature);
				errors++;
			end
			if (got.frame_end !== want.frame_end) begin
				$error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic    point_valid = 1'b0;
	logic    point_ready;
	point_t  point = '0;

	logic    update_valid;
	logic    update_ready = 1'b0;
	update_t update;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = hds_pkg::CFG_GRID_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// shared idling rate of both sides; zero gives a stretch at full rate
	int stall_pct = STALL_PCT;
	int unsigned sent_points = 0;
	int unsigned dropped_pads = 0;

	stencil_scoreboard sb = new();

	heat_diffusion_stencil_step_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_ready  (point_ready),
		.point        (point),
		.update_valid (update_valid),
		.update_ready (update_ready),
		.update       (update),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: check every word taken, then stall at random for the next edge.
	always @(posedge clk) begin
		if (arst_n && update_valid && update_ready) begin
			sb.check_update(update);
		end
		update_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Mix of small, mid-range, near-limit and fully random Q16.16 values, so that
	// both saturation limits and every bit are reached.
	function automatic logic [TEMP_W-1:0] rand_q16();
		logic [31:0] t;
		t = $urandom;
		case ($urandom_range(19))
		0, 1, 2, 3, 4, 5, 6, 7: return {{12{t[19]}}, t[19:0]};
		8, 9, 10, 11, 12, 13:   return {{4{t[27]}}, t[27:0]};
		14, 15, 16:             return t[0] ? TEMP_TOP - 32'(t[15:8])
		                                    : TEMP_BOTTOM + 32'(t[15:8]);
		default:                return t;
		endcase
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p.temperature = rand_q16();
		case ($urandom_range(7))
		0:       p.conductivity = '0;
		1:       p.conductivity = '1;
		default: p.conductivity = COND_W'($urandom);
		endcase
		p.heating = rand_q16();
		p.pad = 1'b0;
		return p;
	endfunction

	// Offer one word after a random gap; valid stays up straight into the next word
	// when there is no gap, so it is never dropped and raised in one step.
	task automatic send_point(input point_t p);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < stall_pct) gap++;
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_valid <= 1'b1;
		point <= p;
		do @(posedge clk); while (!point_ready);
		if (sb.note_point(p)) sent_points++;
		else dropped_pads++;
	endtask

	// Hold the sender until every expected update is out, then let the pipe empty.
	task automatic settle();
		int spins;
		spins = 0;
		point_valid <= 1'b0;
		while (sb.waiting() != 0 && spins < DRAIN_LIMIT) begin
			@(posedge clk);
			spins++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	// Only ever called with the block idle.
	task automatic set_sizes(input bit wr_w, input logic [CFG_DATA_W-1:0] w,
	                         input bit wr_h, input logic [CFG_DATA_W-1:0] h,
	                         input bit wr_spare);
		if (wr_w) cfg_write(hds_pkg::CFG_GRID_WIDTH, w);
		if (wr_h) cfg_write(hds_pkg::CFG_GRID_HEIGHT, h);
		if (wr_spare) cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Random grid words, with the odd stray pad (dropped) and the odd full pause.
	task automatic send_rows(input int n_rows, input int n_cols);
		point_t p;
		for (int r = 0; r < n_rows; r++) begin
			if ($urandom_range(39) == 0) settle();
			for (int c = 0; c < n_cols; c++) begin
				if ($urandom_range(29) == 0) begin
					p = rand_point();
					p.pad = 1'b1;
					send_point(p);
				end
				send_point(rand_point());
			end
		end
	endtask

	// Drain row: pads with junk payload, now and then a data word that must be
	// treated as a pad.
	task automatic send_drain(input int n_cols);
		point_t p;
		for (int c = 0; c < n_cols; c++) begin
			p = rand_point();
			p.pad = ($urandom_range(7) != 0);
			send_point(p);
		end
	endtask

	// 3x3 frame: corners rim_a, edge centres rim_b, one interior point, then a drain
	// row whose middle word lacks the pad flag.
	task automatic directed_frame(input logic [TEMP_W-1:0] rim_a,
	                              input logic [TEMP_W-1:0] rim_b,
	                              input point_t mid);
		point_t p;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				p = rand_point();
				p.temperature = ((r + c) % 2 == 0) ? rim_a : rim_b;
				if (r == 1 && c == 1) p = mid;
				send_point(p);
			end
		end
		for (int c = 0; c < 3; c++) begin
			p = rand_point();
			p.pad = (c != 1);
			send_point(p);
		end
	endtask

	initial begin
		point_t p;
		int unsigned base;
		bit wr_w;
		bit wr_h;
		bit wr_spare;
		logic [CFG_DATA_W-1:0] w_raw;
		logic [CFG_DATA_W-1:0] h_raw;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: width written with junk above bit 10 (masks to zero), height zero;
		// both act as the minimum. A write to the spare index goes nowhere.
		set_sizes(1'b1, 16'hF800, 1'b1, 16'd0, 1'b1);
		p = rand_point();
		p.pad = 1'b1;
		send_point(p);

		// interior point driven past the positive limit
		p.temperature = TEMP_BOTTOM;
		p.conductivity = '1;
		p.heating = TEMP_TOP;
		p.pad = 1'b0;
		directed_frame(TEMP_BOTTOM, TEMP_TOP, p);

		// and past the negative limit, straight on without a settle in between
		p.temperature = TEMP_TOP;
		p.conductivity = '1;
		p.heating = TEMP_BOTTOM;
		directed_frame(TEMP_TOP, TEMP_BOTTOM, p);
		settle();

		// Tallest frame, cut short: a few rows at height 65535, then shrink the height
		// so the row counter sits beyond it and the next row drains.
		set_sizes(1'b1, 16'd3, 1'b1, 16'hFFFF, 1'b0);
		send_rows(5, 3);
		settle();
		set_sizes(1'b0, '0, 1'b1, 16'd3, 1'b0);
		send_drain(3);
		settle();

		// Narrow the grid mid-row: the column counter lands beyond the new width and
		// the next word closes the row as its last column.
		set_sizes(1'b1, 16'd10, 1'b1, 16'd6, 1'b0);
		send_rows(3, 10);
		send_rows(1, 7);
		settle();
		set_sizes(1'b1, 16'd5, 1'b0, '0, 1'b0);
		send_rows(1, 1);
		send_rows(2, 5);
		send_drain(5);
		settle();

		// Width above the store size clamps to it: one full-rate row at the widest
		// grid, then narrow to four columns and finish the frame. The row must close
		// after exactly the store size, or the following rows fall out of step.
		set_sizes(1'b1, 16'd2047, 1'b1, 16'd2, 1'b0);
		stall_pct = 0;
		send_rows(1, sb.cols());
		settle();
		set_sizes(1'b1, 16'd4, 1'b0, '0, 1'b0);
		send_rows(2, sb.cols());
		send_drain(sb.cols());
		settle();
		stall_pct = STALL_PCT;

		// Random frames of small sizes; frames run back to back unless a configuration write comes between.
		// The first stretch runs with no idling on either side.
		base = sent_points;
		while (sent_points - base < RANDOM_POINTS) begin
			wr_w = (sent_points == base) || ($urandom_range(9) < 6);
			wr_h = (sent_points == base) || ($urandom_range(9) < 6);
			wr_spare = ($urandom_range(19) == 0);
			case ($urandom_range(9))
			0:       w_raw = CFG_DATA_W'($urandom_range(2));
			1, 2:    w_raw = CFG_DATA_W'($urandom_range(24, 9));
			default: w_raw = CFG_DATA_W'($urandom_range(8, 3));
			endcase
			h_raw = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(2))
			                                 : CFG_DATA_W'($urandom_range(7, 3));
			if (wr_w || wr_h || wr_spare) begin
				settle();
				set_sizes(wr_w, w_raw, wr_h, h_raw, wr_spare);
			end
			stall_pct = (sent_points - base < RANDOM_POINTS / 3) ? 0 : STALL_PCT;
			send_rows(sb.rows(), sb.cols());
			send_drain(sb.cols());
		end

		settle();
		if (sb.waiting() != 0) begin
			$error("%0d updates never arrived", sb.waiting());
			sb.errors++;
		end
		$display("Run covered %0d grid words (%0d stray pads dropped) over %0d frames,",
		         sent_points, dropped_pads, sb.frames);
		$display("with %0d updates checked, %0d of them clamped at a limit.",
		         sb.checked, sb.clipped);
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
